// ----- design/tsr_pkg.sv -----
`default_nettype none

package tsr_pkg;

  localparam int DefMaxStates      = 1024;
  localparam int DefMaxTransitions = 4096;

  localparam int OpcodeW  = 2;
  localparam int WIndexW  = 12;
  localparam int OffsetW  = 13;
  localparam int SymbolW  = 32;
  localparam int StateIdW = 10;
  localparam int RangeW   = 13;

  typedef enum logic [OpcodeW-1:0] {
    OP_WR_OFFSET = 2'd0,
    OP_WR_SYMBOL = 2'd1,
    OP_LOOKUP    = 2'd2
  } opcode_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_OFF_A = 8'b0000_0010,
    S_OFF_B = 8'b0000_0100,
    S_OFF_C = 8'b0000_1000,
    S_LB    = 8'b0001_0000,
    S_LB_EQ = 8'b0010_0000,
    S_UB    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } search_state_e;

endpackage

`default_nettype wire

// ----- design/tsr_ram.sv -----
`default_nettype none

module tsr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/transition_range_search.sv -----
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | opcode, write_index, write_offset,
//         |           |                           | symbol, lookup_state
// out     | output    | out_valid_o / out_ready_i | found, range_start, range_end
//
// A write transfer gives no result. A lookup reads the slice's offsets in S_OFF_A,
// S_OFF_B and S_OFF_C, probes the lower bound in S_LB with one symbol read per probe,
// checks it in S_LB_EQ, probes the upper bound in S_UB the same way and ends in S_DONE;
// an out-of-range state, an empty slice or a miss goes to S_DONE early.
// Reset clears the control state only; both tables hold nothing until written.
// A new item is accepted while a finished result waits in the output register.
`default_nettype none

module transition_range_search
  import tsr_pkg::*;
#(
  parameter int MAX_STATES      = DefMaxStates,
  parameter int MAX_TRANSITIONS = DefMaxTransitions
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [OpcodeW-1:0]  opcode_i,
  input  wire logic [WIndexW-1:0]  write_index_i,
  input  wire logic [OffsetW-1:0]  write_offset_i,
  input  wire logic [SymbolW-1:0]  symbol_i,
  input  wire logic [StateIdW-1:0] lookup_state_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     found_o,
  output logic      [RangeW-1:0]   range_start_o,
  output logic      [RangeW-1:0]   range_end_o
);

  localparam int OffDepth = MAX_STATES + 1;
  localparam int OAW      = $clog2(OffDepth);
  localparam int TAW      = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int IW       = $clog2(MAX_TRANSITIONS + 1);

  search_state_e state_q, state_d;

  logic [SymbolW-1:0] sym_q, sym_d;
  logic [OAW-1:0]     st_q, st_d;
  logic [IW-1:0]      lo_q, lo_d, hi_q, hi_d, last_q, last_d;
  logic [IW-1:0]      first_q, first_d, mid_q, mid_d;
  logic               res_found_q, res_found_d;
  logic [IW-1:0]      res_start_q, res_start_d, res_end_q, res_end_d;
  logic               out_valid_q, out_valid_d;
  logic               found_q, found_d;
  logic [RangeW-1:0]  start_q, start_d, end_q, end_d;

  logic               in_fire;
  logic [31:0]        widx_ext, st_ext, start_ext, end_ext;
  logic               off_we, sym_we;
  logic [OAW-1:0]     off_raddr;
  logic [TAW-1:0]     sym_raddr;
  logic [OffsetW-1:0] off_rdata;
  logic [SymbolW-1:0] sym_rdata;
  logic [IW-1:0]      lo_n, hi_n, addr_n;

  function automatic logic [IW-1:0] clamp_off(logic [OffsetW-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x > 32'(MAX_TRANSITIONS)) begin
      x = 32'(MAX_TRANSITIONS);
    end
    return x[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] mid_of(logic [IW-1:0] a, logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[IW:1];
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign widx_ext   = 32'(write_index_i);
  assign st_ext     = 32'(lookup_state_i);

  assign off_we = in_fire && (opcode_i == OP_WR_OFFSET) && (widx_ext < 32'(OffDepth));
  assign sym_we = in_fire && (opcode_i == OP_WR_SYMBOL) && (widx_ext < 32'(MAX_TRANSITIONS));

  tsr_ram #(
    .Width (OffsetW),
    .Depth (OffDepth)
  ) u_offset_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (widx_ext[OAW-1:0]),
    .wdata_i (write_offset_i),
    .raddr_i (off_raddr),
    .rdata_o (off_rdata)
  );

  tsr_ram #(
    .Width (SymbolW),
    .Depth (MAX_TRANSITIONS)
  ) u_symbol_ram (
    .clk_i   (clk_i),
    .we_i    (sym_we),
    .waddr_i (widx_ext[TAW-1:0]),
    .wdata_i (symbol_i),
    .raddr_i (sym_raddr),
    .rdata_o (sym_rdata)
  );

  assign start_ext = 32'(res_start_q);
  assign end_ext   = 32'(res_end_q);

  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    st_d        = st_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    last_d      = last_q;
    first_d     = first_q;
    mid_d       = mid_q;
    res_found_d = res_found_q;
    res_start_d = res_start_q;
    res_end_d   = res_end_q;
    found_d     = found_q;
    start_d     = start_q;
    end_d       = end_q;
    out_valid_d = out_valid_q && !out_ready_i;
    off_raddr   = st_q;
    lo_n        = lo_q;
    hi_n        = hi_q;
    addr_n      = mid_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire && (opcode_i == OP_LOOKUP)) begin
          sym_d       = symbol_i;
          st_d        = st_ext[OAW-1:0];
          res_found_d = 1'b0;
          res_start_d = '0;
          res_end_d   = '0;
          if (st_ext < 32'(MAX_STATES)) begin
            state_d = S_OFF_A;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_OFF_A: begin
        off_raddr = st_q;
        state_d   = S_OFF_B;
      end
      S_OFF_B: begin
        off_raddr = st_q + OAW'(1);
        lo_d      = clamp_off(off_rdata);
        state_d   = S_OFF_C;
      end
      S_OFF_C: begin
        hi_n = clamp_off(off_rdata);
        if (lo_q >= hi_n) begin
          state_d = S_DONE;
        end else begin
          hi_d    = hi_n;
          last_d  = hi_n;
          addr_n  = mid_of(lo_q, hi_n);
          mid_d   = addr_n;
          state_d = S_LB;
        end
      end
      S_LB: begin
        if ($signed(sym_rdata) < $signed(sym_q)) begin
          lo_n = mid_q + IW'(1);
          hi_n = hi_q;
        end else begin
          lo_n = lo_q;
          hi_n = mid_q;
        end
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          addr_n = mid_of(lo_n, hi_n);
          mid_d  = addr_n;
        end else begin
          addr_n  = lo_n;
          state_d = S_LB_EQ;
        end
      end
      S_LB_EQ: begin
        if ((lo_q >= last_q) || (sym_rdata != sym_q)) begin
          state_d = S_DONE;
        end else begin
          first_d = lo_q;
          hi_d    = last_q;
          addr_n  = mid_of(lo_q, last_q);
          mid_d   = addr_n;
          state_d = S_UB;
        end
      end
      S_UB: begin
        if ($signed(sym_q) < $signed(sym_rdata)) begin
          lo_n = lo_q;
          hi_n = mid_q;
        end else begin
          lo_n = mid_q + IW'(1);
          hi_n = hi_q;
        end
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          addr_n = mid_of(lo_n, hi_n);
          mid_d  = addr_n;
        end else begin
          res_found_d = 1'b1;
          res_start_d = first_q;
          res_end_d   = lo_n;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          found_d     = res_found_q;
          start_d     = start_ext[RangeW-1:0];
          end_d       = end_ext[RangeW-1:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    sym_raddr = addr_n[TAW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q       <= sym_d;
    st_q        <= st_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    last_q      <= last_d;
    first_q     <= first_d;
    mid_q       <= mid_d;
    res_found_q <= res_found_d;
    res_start_q <= res_start_d;
    res_end_q   <= res_end_d;
    found_q     <= found_d;
    start_q     <= start_d;
    end_q       <= end_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign range_start_o = start_q;
  assign range_end_o   = end_q;

  // The search window is never empty while a probe is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LB || state_q == S_UB) |-> (lo_q < hi_q && hi_q <= last_q))
    else $error("search window empty or beyond slice end");

  // The upper-bound search never moves below the first match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UB) |-> (first_q <= lo_q))
    else $error("upper-bound search moved below first match");

  // A miss reports an empty range at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (range_start_o == '0 && range_end_o == '0))
    else $error("miss reported with nonzero range");

  // Only the idle state accepts a transfer, so the next state is S_IDLE, S_OFF_A or S_DONE.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_IDLE || state_q == S_OFF_A ||
                                    state_q == S_DONE))
    else $error("unexpected state after accepted transfer");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import tsr_pkg::*;

  localparam logic [OpcodeW-1:0] OP_UNUSED = 2'd3;
  localparam int OffsetMax = (1 << OffsetW) - 1;
  localparam int IndexMax  = (1 << WIndexW) - 1;
  localparam int StateMax  = (1 << StateIdW) - 1;

  localparam int SYM_NARROW  = 0;
  localparam int SYM_WIDE    = 1;
  localparam int SYM_EXTREME = 2;

  typedef struct {
    logic [OpcodeW-1:0]  opcode;
    logic [WIndexW-1:0]  write_index;
    logic [OffsetW-1:0]  write_offset;
    logic [SymbolW-1:0]  symbol;
    logic [StateIdW-1:0] lookup_state;
  } xfer_t;

  typedef struct {
    logic              found;
    logic [RangeW-1:0] start_idx;
    logic [RangeW-1:0] end_idx;
  } range_t;

  class range_checker;
    bit [OffsetW-1:0] offsets [DefMaxStates+1];
    bit [SymbolW-1:0] symbols [DefMaxTransitions];
    bit               offset_known [DefMaxStates+1];
    bit               symbol_known [DefMaxTransitions];
    range_t           expected_ranges [$];
    int               errors;
    int               lookups;
    int               hits;

    function int sat_offset(bit [OffsetW-1:0] v);
      return (v > DefMaxTransitions) ? DefMaxTransitions : int'(v);
    endfunction

    function range_t search_range(int state, bit [SymbolW-1:0] sym);
      range_t r;
      int lo, hi, mid, last, first;
      r.found = 1'b0;
      r.start_idx = '0;
      r.end_idx = '0;
      if (state >= DefMaxStates) return r;
      lo = sat_offset(offsets[state]);
      hi = sat_offset(offsets[state+1]);
      if (lo >= hi) return r;
      last = hi;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if ($signed(symbols[mid]) < $signed(sym)) lo = mid + 1;
        else hi = mid;
      end
      if (lo >= last || symbols[lo] != sym) return r;
      first = lo;
      hi = last;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if ($signed(sym) < $signed(symbols[mid])) hi = mid;
        else lo = mid + 1;
      end
      r.found = 1'b1;
      r.start_idx = first[RangeW-1:0];
      r.end_idx = lo[RangeW-1:0];
      return r;
    endfunction

    // A lookup may only touch entries that have already been written.
    function bit lookup_safe(int state);
      int lo, hi, i;
      if (!offset_known[state] || !offset_known[state+1]) return 1'b0;
      lo = sat_offset(offsets[state]);
      hi = sat_offset(offsets[state+1]);
      for (i = lo; i < hi; i++) begin
        if (!symbol_known[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_transfer(xfer_t x);
      range_t r;
      case (x.opcode)
        OP_WR_OFFSET: begin
          if (x.write_index <= DefMaxStates) begin
            offsets[x.write_index] = x.write_offset;
            offset_known[x.write_index] = 1'b1;
          end
        end
        OP_WR_SYMBOL: begin
          if (x.write_index < DefMaxTransitions) begin
            symbols[x.write_index] = x.symbol;
            symbol_known[x.write_index] = 1'b1;
          end
        end
        OP_LOOKUP: begin
          r = search_range(int'(x.lookup_state), x.symbol);
          expected_ranges.insert(expected_ranges.size(), r);
          lookups++;
          if (r.found) hits++;
        end
        default: ;
      endcase
    endfunction

    function void check_range(logic found, logic [RangeW-1:0] s, logic [RangeW-1:0] e);
      range_t r;
      if (expected_ranges.size() == 0) begin
        $error("result transfer with no lookup pending: found %0d, start %0d, end %0d",
               found, s, e);
        errors++;
        return;
      end
      r = expected_ranges.pop_front();
      if (found !== r.found) begin
        $error("found: expected %0d, actual %0d", r.found, found);
        errors++;
      end
      if (s !== r.start_idx) begin
        $error("range_start: expected %0d, actual %0d", r.start_idx, s);
        errors++;
      end
      if (e !== r.end_idx) begin
        $error("range_end: expected %0d, actual %0d", r.end_idx, e);
        errors++;
      end
    endfunction

    function int pending();
      return expected_ranges.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [OpcodeW-1:0]  opcode_i = '0;
  logic [WIndexW-1:0]  write_index_i = '0;
  logic [OffsetW-1:0]  write_offset_i = '0;
  logic [SymbolW-1:0]  symbol_i = '0;
  logic [StateIdW-1:0] lookup_state_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                found_o;
  logic [RangeW-1:0]   range_start_o;
  logic [RangeW-1:0]   range_end_o;

  range_checker board = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int active_items = 0;
  int total_items = 0;
  int built_states [$];

  transition_range_search dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .write_index_i  (write_index_i),
    .write_offset_i (write_offset_i),
    .symbol_i       (symbol_i),
    .lookup_state_i (lookup_state_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .range_start_o  (range_start_o),
    .range_end_o    (range_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_range(found_o, range_start_o, range_end_o);
    end
    out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [SymbolW-1:0] rand_symbol(int mode);
    case (mode)
      SYM_NARROW: return SymbolW'($urandom_range(0, 16)) - 32'd8;
      SYM_WIDE:   return $urandom;
      default: begin
        case ($urandom_range(0, 6))
          0:       return 32'h8000_0000;
          1:       return 32'h8000_0001;
          2:       return 32'hFFFF_FFFF;
          3:       return 32'h0000_0000;
          4:       return 32'h0000_0001;
          5:       return 32'h7FFF_FFFE;
          default: return 32'h7FFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // Fields that the opcode does not use are driven with random values.
  task automatic send_item(logic [OpcodeW-1:0] op, int idx, int off, logic [SymbolW-1:0] sym,
                           int st);
    xfer_t x;
    bit    writes;
    writes = (op == OP_WR_OFFSET) || (op == OP_WR_SYMBOL);
    x.opcode = op;
    x.write_index = writes ? WIndexW'(idx) : WIndexW'($urandom);
    x.write_offset = (op == OP_WR_OFFSET) ? OffsetW'(off) : OffsetW'($urandom);
    x.symbol = (op == OP_WR_SYMBOL || op == OP_LOOKUP) ? sym : SymbolW'($urandom);
    x.lookup_state = (op == OP_LOOKUP) ? StateIdW'(st) : StateIdW'($urandom);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= x.opcode;
    write_index_i <= x.write_index;
    write_offset_i <= x.write_offset;
    symbol_i <= x.symbol;
    lookup_state_i <= x.lookup_state;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_transfer(x);
    total_items++;
    if (!(op == OP_UNUSED || (op == OP_WR_OFFSET && idx > DefMaxStates))) active_items++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  // Loads one state's slice with sorted symbols, then looks it up.
  task automatic build_segment();
    int s, n, b, lo_off, hi_off, pick, mode, m, j, k;
    logic [SymbolW-1:0] vals [$];
    logic [SymbolW-1:0] v, key;
    s = $urandom_range(0, StateMax);
    mode = $urandom_range(0, 2);
    pick = $urandom_range(0, 99);
    n = 0;
    b = 0;
    if (pick < 80) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 64) : $urandom_range(0, 8);
      b = $urandom_range(0, DefMaxTransitions - n);
      lo_off = b;
      hi_off = b + n;
    end else if (pick < 90) begin
      n = $urandom_range(1, 8);
      b = DefMaxTransitions - n;
      lo_off = b;
      hi_off = $urandom_range(DefMaxTransitions + 1, OffsetMax);
    end else if (pick < 95) begin
      lo_off = $urandom_range(1, DefMaxTransitions);
      hi_off = $urandom_range(0, lo_off - 1);
    end else begin
      lo_off = $urandom_range(DefMaxTransitions + 1, OffsetMax);
      hi_off = $urandom_range(0, OffsetMax);
    end
    for (j = 0; j < n; j++) begin
      v = rand_symbol(mode);
      k = 0;
      while (k < vals.size() && $signed(vals[k]) <= $signed(v)) k++;
      vals.insert(k, v);
    end
    if ($urandom_range(0, 1)) begin
      send_item(OP_WR_OFFSET, s, lo_off, 0, 0);
      send_item(OP_WR_OFFSET, s + 1, hi_off, 0, 0);
    end else begin
      send_item(OP_WR_OFFSET, s + 1, hi_off, 0, 0);
      send_item(OP_WR_OFFSET, s, lo_off, 0, 0);
    end
    for (j = 0; j < n; j++) send_item(OP_WR_SYMBOL, b + j, 0, vals[j], 0);
    built_states.insert(built_states.size(), s);
    m = $urandom_range(1, 4);
    for (j = 0; j < m; j++) begin
      k = $urandom_range(0, 9);
      if (n > 0 && k < 6) key = vals[$urandom_range(0, n - 1)];
      else if (n > 0 && k < 8) key = vals[$urandom_range(0, n - 1)] + ((k == 6) ? 32'd1 : '1);
      else key = rand_symbol(mode);
      send_item(OP_LOOKUP, 0, 0, key, s);
    end
  endtask

  task automatic send_noise();
    int pick, s, tries;
    bit sent;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      send_item(OP_UNUSED, 0, 0, 0, 0);
    end else if (pick < 4) begin
      send_item(OP_WR_OFFSET, $urandom_range(DefMaxStates + 1, IndexMax),
                $urandom_range(0, OffsetMax), 0, 0);
    end else if (pick < 6) begin
      send_item(OP_WR_SYMBOL, $urandom_range(0, IndexMax), 0, $urandom, 0);
    end else begin
      tries = 0;
      sent = 1'b0;
      while (tries < 8 && !sent && built_states.size() > 0) begin
        s = built_states[$urandom_range(0, built_states.size() - 1)];
        if (board.lookup_safe(s)) begin
          send_item(OP_LOOKUP, 0, 0, rand_symbol($urandom_range(0, 2)), s);
          sent = 1'b1;
        end
        tries++;
      end
    end
  endtask

  initial begin
    int idle_tab [4] = '{0, 80, 0, 15};
    int stall_tab [4] = '{0, 0, 80, 15};
    int phase, quota;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_UNUSED, 0, 0, 0, 0);
    send_item(OP_WR_OFFSET, IndexMax, OffsetMax, 0, 0);
    send_item(OP_WR_OFFSET, DefMaxStates + 1, 0, 0, 0);
    send_item(OP_WR_OFFSET, 0, 0, 0, 0);
    send_item(OP_WR_OFFSET, 1, 4, 0, 0);
    send_item(OP_WR_SYMBOL, 0, 0, 32'h8000_0000, 0);
    send_item(OP_WR_SYMBOL, 1, 0, 32'hFFFF_FFFF, 0);
    send_item(OP_WR_SYMBOL, 2, 0, 32'hFFFF_FFFF, 0);
    send_item(OP_WR_SYMBOL, 3, 0, 32'h7FFF_FFFF, 0);
    send_item(OP_LOOKUP, 0, 0, 32'h8000_0000, 0);
    send_item(OP_LOOKUP, 0, 0, 32'hFFFF_FFFF, 0);
    send_item(OP_LOOKUP, 0, 0, 32'h7FFF_FFFF, 0);
    send_item(OP_LOOKUP, 0, 0, 32'h0000_0000, 0);
    send_item(OP_LOOKUP, 0, 0, 32'hFFFF_FFFE, 0);
    send_item(OP_WR_OFFSET, 2, 4, 0, 0);
    send_item(OP_LOOKUP, 0, 0, 32'h0000_0000, 1);
    send_item(OP_WR_OFFSET, 3, 3, 0, 0);
    send_item(OP_LOOKUP, 0, 0, 32'hFFFF_FFFF, 2);
    send_item(OP_WR_OFFSET, StateMax, DefMaxTransitions - 2, 0, 0);
    send_item(OP_WR_OFFSET, DefMaxStates, OffsetMax, 0, 0);
    send_item(OP_WR_SYMBOL, DefMaxTransitions - 2, 0, 32'd5, 0);
    send_item(OP_WR_SYMBOL, DefMaxTransitions - 1, 0, 32'd5, 0);
    send_item(OP_LOOKUP, 0, 0, 32'd5, StateMax);
    send_item(OP_LOOKUP, 0, 0, 32'd6, StateMax);
    send_item(OP_LOOKUP, 0, 0, 32'd4, StateMax);
    drain_results();

    for (phase = 0; phase < 4; phase++) begin
      sender_idle_pct = idle_tab[phase];
      receiver_stall_pct = stall_tab[phase];
      quota = active_items + 325;
      while (active_items < quota) begin
        if ($urandom_range(0, 99) < 70) build_segment();
        else send_noise();
        if ($urandom_range(0, 39) == 0) drain_results();
      end
      drain_results();
    end

    repeat (64) @(posedge clk_i);
    $display("Sent %0d transfers (%0d not ignored) over four handshake phases.",
             total_items, active_items);
    $display("Checked %0d lookups, %0d of them with a matching range.",
             board.lookups, board.hits);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tsr_pkg.sv
design/tsr_ram.sv
design/transition_range_search.sv
tb/sv/tb_top.sv
